>>> rtl/elx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elx_pkg
// shared types, character codes, operator codes and byte classifier
// ----------------------------------------------------------------------------
package elx_pkg;

  // token kinds, also the character classes
  typedef enum logic [4:0] {
    KIND_END    = 5'd0,
    KIND_LETTER = 5'd1,
    KIND_DIGIT  = 5'd2,
    KIND_DOT    = 5'd3,
    KIND_BANG   = 5'd4,
    KIND_HASH   = 5'd5,
    KIND_LPAREN = 5'd6,
    KIND_RPAREN = 5'd7,
    KIND_TIMES  = 5'd8,
    KIND_PLUS   = 5'd9,
    KIND_MINUS  = 5'd10,
    KIND_DIV    = 5'd11,
    KIND_COLON  = 5'd12,
    KIND_LT     = 5'd13,
    KIND_EQ     = 5'd14,
    KIND_GT     = 5'd15,
    KIND_QUEST  = 5'd16,
    KIND_OTHER  = 5'd17
  } kind_t;

  // character codes
  localparam logic [7:0] CH_NUL        = 8'd0;
  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_BANG       = 8'd33;
  localparam logic [7:0] CH_HASH       = 8'd35;
  localparam logic [7:0] CH_LPAREN     = 8'd40;
  localparam logic [7:0] CH_RPAREN     = 8'd41;
  localparam logic [7:0] CH_STAR       = 8'd42;
  localparam logic [7:0] CH_PLUS       = 8'd43;
  localparam logic [7:0] CH_MINUS      = 8'd45;
  localparam logic [7:0] CH_DOT        = 8'd46;
  localparam logic [7:0] CH_SLASH      = 8'd47;
  localparam logic [7:0] CH_ZERO       = 8'd48;
  localparam logic [7:0] CH_COLON      = 8'd58;
  localparam logic [7:0] CH_LT         = 8'd60;
  localparam logic [7:0] CH_EQUAL      = 8'd61;
  localparam logic [7:0] CH_GT         = 8'd62;
  localparam logic [7:0] CH_QUEST      = 8'd63;
  localparam logic [7:0] CH_UPPER_A    = 8'd65;
  localparam logic [7:0] CH_UPPER_END  = 8'd91;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;
  localparam logic [7:0] CH_LOWER_A    = 8'd97;
  localparam logic [7:0] CH_LOWER_END  = 8'd123;

  // operator codes within a kind
  localparam logic signed [3:0] OP_NONE    = -4'sd1;
  localparam logic signed [3:0] OP_NUMERIC = 4'sd0;
  localparam logic signed [3:0] OP_IDENT   = 4'sd1;
  localparam logic signed [3:0] OP_TIMES   = 4'sd0;
  localparam logic signed [3:0] OP_DIV     = 4'sd1;
  localparam logic signed [3:0] OP_UPLUS   = 4'sd0;
  localparam logic signed [3:0] OP_UMINUS  = 4'sd1;
  localparam logic signed [3:0] OP_PLUS    = 4'sd2;
  localparam logic signed [3:0] OP_MINUS   = 4'sd3;
  localparam logic signed [3:0] OP_LT      = 4'sd4;
  localparam logic signed [3:0] OP_GT      = 4'sd5;
  localparam logic signed [3:0] OP_EQEQ    = 4'sd6;
  localparam logic signed [3:0] OP_ASSIGN  = 4'sd7;
  localparam logic signed [3:0] OP_QUEST   = 4'sd0;
  localparam logic signed [3:0] OP_COLON   = 4'sd0;

  localparam logic signed [2:0] ARITY_NONE = -3'sd1;
  localparam logic signed [4:0] PREC_NONE  = -5'sd1;

  // text limits
  localparam logic [15:0] POS_MAX  = 16'hFFFF;
  localparam logic [16:0] LEN_MAX  = 17'h10000;
  localparam logic [1:0]  DOTS_SAT = 2'd2;

  // token queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic               last;
    logic [16:0]        length;
    logic [15:0]        start;
    logic signed [4:0]  prec;
    logic signed [2:0]  arity;
    logic signed [3:0]  code;
    kind_t              kind;
  } token_t;

  // up to two tokens produced by one text byte
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } tok_push_t;

  typedef struct packed {
    logic       eot;
    logic [7:0] text_byte;
  } lex_in_t;

  function automatic kind_t classify(input logic [7:0] b);
    kind_t k;
    if (b == CH_NUL) begin
      k = KIND_END;
    end else if (b >= CH_ZERO && b < CH_COLON) begin
      k = KIND_DIGIT;
    end else if ((b >= CH_UPPER_A && b < CH_UPPER_END) ||
                 (b >= CH_LOWER_A && b < CH_LOWER_END) || b == CH_UNDERSCORE) begin
      k = KIND_LETTER;
    end else begin
      unique case (b)
        CH_BANG:   k = KIND_BANG;
        CH_HASH:   k = KIND_HASH;
        CH_LPAREN: k = KIND_LPAREN;
        CH_RPAREN: k = KIND_RPAREN;
        CH_STAR:   k = KIND_TIMES;
        CH_PLUS:   k = KIND_PLUS;
        CH_MINUS:  k = KIND_MINUS;
        CH_DOT:    k = KIND_DOT;
        CH_SLASH:  k = KIND_DIV;
        CH_COLON:  k = KIND_COLON;
        CH_LT:     k = KIND_LT;
        CH_EQUAL:  k = KIND_EQ;
        CH_GT:     k = KIND_GT;
        CH_QUEST:  k = KIND_QUEST;
        default:   k = KIND_OTHER;
      endcase
    end
    return k;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
  endfunction

endpackage

>>> rtl/elx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elx_core
// lexer state and the one-pass token logic for one text byte
// ----------------------------------------------------------------------------
module elx_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  elx_pkg::lex_in_t    lex_in,
  output elx_pkg::tok_push_t  push
);

  typedef struct packed {
    logic [15:0]     position;
    elx_pkg::kind_t  prev_class;
    logic            at_start;
    logic            in_word;
    logic [15:0]     word_start;
    logic [16:0]     word_length;
    logic [1:0]      word_first;
    logic            word_numeric;
    logic [1:0]      word_dots;
    logic            eq_pending;
    logic [15:0]     eq_position;
  } lex_state_t;

  localparam lex_state_t ST_RESET = '{
    position:     16'd0,
    prev_class:   elx_pkg::KIND_END,
    at_start:     1'b1,
    in_word:      1'b0,
    word_start:   16'd0,
    word_length:  17'd0,
    word_first:   2'd0,
    word_numeric: 1'b1,
    word_dots:    2'd0,
    eq_pending:   1'b0,
    eq_position:  16'd0
  };

  lex_state_t st;
  lex_state_t st_next;

  function automatic elx_pkg::token_t op_token(input elx_pkg::kind_t cls, input logic unary,
                                               input logic [15:0] pos);
    elx_pkg::token_t t;
    t.kind   = cls;
    t.start  = pos;
    t.length = 17'd1;
    t.last   = 1'b0;
    unique case (cls)
      elx_pkg::KIND_TIMES: begin
        t.code = elx_pkg::OP_TIMES; t.arity = 3'sd2; t.prec = 5'sd3;
      end
      elx_pkg::KIND_DIV: begin
        t.code = elx_pkg::OP_DIV; t.arity = 3'sd2; t.prec = 5'sd3;
      end
      elx_pkg::KIND_PLUS: begin
        if (unary) begin
          t.code = elx_pkg::OP_UPLUS; t.arity = 3'sd1; t.prec = 5'sd2;
        end else begin
          t.code = elx_pkg::OP_PLUS; t.arity = 3'sd2; t.prec = 5'sd4;
        end
      end
      elx_pkg::KIND_MINUS: begin
        if (unary) begin
          t.code = elx_pkg::OP_UMINUS; t.arity = 3'sd1; t.prec = 5'sd2;
        end else begin
          t.code = elx_pkg::OP_MINUS; t.arity = 3'sd2; t.prec = 5'sd4;
        end
      end
      elx_pkg::KIND_LT: begin
        t.code = elx_pkg::OP_LT; t.arity = 3'sd2; t.prec = 5'sd6;
      end
      elx_pkg::KIND_GT: begin
        t.code = elx_pkg::OP_GT; t.arity = 3'sd2; t.prec = 5'sd6;
      end
      elx_pkg::KIND_QUEST: begin
        t.code = elx_pkg::OP_QUEST; t.arity = 3'sd0; t.prec = 5'sd13;
      end
      elx_pkg::KIND_COLON: begin
        t.code = elx_pkg::OP_COLON; t.arity = 3'sd3; t.prec = 5'sd13;
      end
      default: begin
        t.code = elx_pkg::OP_NONE; t.arity = elx_pkg::ARITY_NONE;
        t.prec = elx_pkg::PREC_NONE;
      end
    endcase
    return t;
  endfunction

  elx_pkg::kind_t  cls;
  logic            ws;
  logic            word_char;
  logic            terminate;
  logic            unary;
  logic            numeric;
  logic            advance;
  logic            first_vld;
  logic            sec_vld;
  elx_pkg::token_t word_tok;
  elx_pkg::token_t eq1_tok;
  elx_pkg::token_t eq2_tok;
  elx_pkg::token_t end_tok;
  elx_pkg::token_t op_tok;
  elx_pkg::token_t first_tok;
  elx_pkg::token_t sec_tok;

  always_comb begin
    cls       = elx_pkg::classify(lex_in.text_byte);
    ws        = elx_pkg::is_space(lex_in.text_byte);
    word_char = cls == elx_pkg::KIND_LETTER || cls == elx_pkg::KIND_DIGIT ||
                cls == elx_pkg::KIND_DOT;
    terminate = lex_in.eot || lex_in.text_byte == elx_pkg::CH_NUL;

    unary = st.at_start ||
            st.prev_class == elx_pkg::KIND_TIMES  || st.prev_class == elx_pkg::KIND_DIV ||
            st.prev_class == elx_pkg::KIND_PLUS   || st.prev_class == elx_pkg::KIND_MINUS ||
            st.prev_class == elx_pkg::KIND_LT     || st.prev_class == elx_pkg::KIND_EQ ||
            st.prev_class == elx_pkg::KIND_GT     || st.prev_class == elx_pkg::KIND_LPAREN ||
            st.prev_class == elx_pkg::KIND_QUEST  || st.prev_class == elx_pkg::KIND_COLON;

    // a lone dot is an identifier, two dots spoil a number
    numeric = st.word_numeric && st.word_dots < elx_pkg::DOTS_SAT &&
              !(st.word_length == 17'd1 && st.word_first == 2'(elx_pkg::KIND_DOT));

    word_tok.kind   = elx_pkg::kind_t'({3'b000, st.word_first});
    word_tok.code   = numeric ? elx_pkg::OP_NUMERIC : elx_pkg::OP_IDENT;
    word_tok.arity  = 3'sd0;
    word_tok.prec   = 5'sd0;
    word_tok.start  = st.word_start;
    word_tok.length = st.word_length;
    word_tok.last   = 1'b0;

    eq1_tok.kind   = elx_pkg::KIND_EQ;
    eq1_tok.code   = elx_pkg::OP_ASSIGN;
    eq1_tok.arity  = 3'sd2;
    eq1_tok.prec   = 5'sd14;
    eq1_tok.start  = st.eq_position;
    eq1_tok.length = 17'd1;
    eq1_tok.last   = 1'b0;

    eq2_tok        = eq1_tok;
    eq2_tok.code   = elx_pkg::OP_EQEQ;
    eq2_tok.prec   = 5'sd7;
    eq2_tok.length = 17'd2;

    end_tok.kind   = elx_pkg::KIND_END;
    end_tok.code   = elx_pkg::OP_NONE;
    end_tok.arity  = elx_pkg::ARITY_NONE;
    end_tok.prec   = elx_pkg::PREC_NONE;
    end_tok.start  = st.position;
    end_tok.length = 17'd0;
    end_tok.last   = 1'b1;

    op_tok = op_token(cls, unary, st.position);

    st_next   = st;
    first_vld = 1'b0;
    first_tok = word_tok;
    sec_vld   = 1'b0;
    sec_tok   = op_tok;
    advance   = 1'b0;

    if (terminate) begin
      // word and pending equal sign never coexist
      first_vld = st.in_word || st.eq_pending;
      first_tok = st.in_word ? word_tok : eq1_tok;
      sec_vld   = 1'b1;
      sec_tok   = end_tok;
      st_next   = ST_RESET;
    end else if (st.in_word && word_char) begin
      advance = 1'b1;
      if (st.word_length != elx_pkg::LEN_MAX) begin
        st_next.word_length = st.word_length + 17'd1;
      end
      if (cls == elx_pkg::KIND_LETTER) begin
        st_next.word_numeric = 1'b0;
      end
      if (cls == elx_pkg::KIND_DOT && st.word_dots < elx_pkg::DOTS_SAT) begin
        st_next.word_dots = st.word_dots + 2'd1;
      end
    end else if (st.eq_pending && cls == elx_pkg::KIND_EQ) begin
      advance            = 1'b1;
      first_vld          = 1'b1;
      first_tok          = eq2_tok;
      st_next.eq_pending = 1'b0;
    end else begin
      advance = 1'b1;
      if (st.in_word) begin
        first_vld       = 1'b1;
        first_tok       = word_tok;
        st_next.in_word = 1'b0;
      end else if (st.eq_pending) begin
        first_vld          = 1'b1;
        first_tok          = eq1_tok;
        st_next.eq_pending = 1'b0;
      end
      if (!ws) begin
        if (word_char) begin
          st_next.in_word      = 1'b1;
          st_next.word_start   = st.position;
          st_next.word_length  = 17'd1;
          st_next.word_first   = cls[1:0];
          st_next.word_numeric = cls != elx_pkg::KIND_LETTER;
          st_next.word_dots    = (cls == elx_pkg::KIND_DOT) ? 2'd1 : 2'd0;
        end else if (cls == elx_pkg::KIND_EQ) begin
          st_next.eq_pending  = 1'b1;
          st_next.eq_position = st.position;
        end else begin
          sec_vld = 1'b1;
        end
      end
    end

    if (advance) begin
      st_next.prev_class = ws ? elx_pkg::KIND_OTHER : cls;
      st_next.at_start   = 1'b0;
      if (st.position != elx_pkg::POS_MAX) begin
        st_next.position = st.position + 16'd1;
      end
    end

    push.count  = step ? ({1'b0, first_vld} + {1'b0, sec_vld}) : 2'd0;
    push.first  = first_vld ? first_tok : sec_tok;
    push.second = sec_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end

  a_word_eq_exclusive : assert property (@(posedge clk) disable iff (rst)
    !(st.in_word && st.eq_pending))
    else $error("word and pending equal sign held together");

  a_restart_after_end : assert property (@(posedge clk) disable iff (rst)
    step && terminate |=> st.at_start && st.position == 16'd0 && !st.in_word)
    else $error("lexer did not restart after end of text");

  a_end_token_last : assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> !push.first.last)
    else $error("end token placed ahead of another token");

endmodule

>>> rtl/elx_token_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elx_token_fifo
// small token queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module elx_token_fifo (
  input  logic                clk,
  input  logic                rst,
  input  elx_pkg::tok_push_t  push,
  input  logic                pop,
  output elx_pkg::token_t     head,
  output logic                not_empty,
  output logic                room2
);

  elx_pkg::token_t                mem [elx_pkg::FIFO_DEPTH];
  logic [elx_pkg::PTR_W-1:0]      wr_ptr;
  logic [elx_pkg::PTR_W-1:0]      rd_ptr;
  logic [elx_pkg::CNT_W-1:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + elx_pkg::PTR_W'(push.count);
      rd_ptr <= rd_ptr + elx_pkg::PTR_W'(pop);
      count  <= count + elx_pkg::CNT_W'(push.count) - elx_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + elx_pkg::PTR_W'(1)] <= push.second;
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = count != '0;
  assign room2     = count <= elx_pkg::CNT_W'(elx_pkg::FIFO_DEPTH - 2);

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= elx_pkg::CNT_W'(elx_pkg::FIFO_DEPTH))
    else $error("token queue overfilled");

  a_push_room : assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room2)
    else $error("tokens pushed without room for two");

endmodule

>>> rtl/expression_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_lexer
// streaming lexer: text bytes in, expression tokens out
// ----------------------------------------------------------------------------
// path: a byte is taken from s_* into the input register, the core then takes it
//   and writes the token it completes into the token queue, whose head is on m_*
// throughput: one byte per cycle while the queue has room; a byte that closes a
//   word or a held '=' and also makes its own token pushes two entries; with the
//   output side taking one per cycle the queue absorbs two such extra tokens, each
//   later one stalls input, and bytes that make no token let the queue drain again
// reset: synchronous rst empties the input register and token queue and puts
//   the lexer at the start of a new text, no clearing pass
// ----------------------------------------------------------------------------
module expression_lexer (
  input  logic        clk,
  input  logic        rst,
  // input request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  // token stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [4:0] token_kind, [8:5] op_code, [11:9] op_arity,
                                 // [16:12] op_precedence, [32:17] start_position,
                                 // [49:33] token_length, [55:50] zero
  output logic        m_tlast    // last_token
);

  // input register
  logic               in_valid;
  elx_pkg::lex_in_t   in_item;

  // lexer step and token queue
  logic               step;
  logic               room2;
  logic               not_empty;
  logic               pop;
  elx_pkg::tok_push_t push;
  elx_pkg::token_t    head;

  // a byte is worked on once the queue can take both of its possible tokens
  assign step     = in_valid && room2;
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.text_byte <= s_tdata;
      in_item.eot       <= s_tlast;
    end
  end

  elx_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .lex_in (in_item),
    .push   (push)
  );

  elx_token_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  // output side reads the queue head directly
  assign m_tvalid = not_empty;
  assign pop      = not_empty && m_tready;
  assign m_tdata  = {6'b000000, head.length, head.start, head.prec, head.arity,
                     head.code, head.kind};
  assign m_tlast  = head.last;

endmodule

>>> test/expression_lexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_lexer_tb
// self-checking bench: byte requests in, tokens checked against a local lexer
// ----------------------------------------------------------------------------
// a short directed text set covers every operator, unary and binary sign,
// '=' and '==', lone and double dots, bytes above 127 and both text ends.
// Random texts follow in three idling phases. The last phase holds the token
// side off for a long stretch while requests keep coming.
// ----------------------------------------------------------------------------
module expression_lexer_tb;
  import elx_pkg::*;

  localparam int STALL_LIMIT = 5000;   // cycles without any handshake
  localparam int HOLD_CYCLES = 300;    // long back-pressure stretch
  localparam int PHASE_ITEMS = 430;    // random requests per phase

  // operator properties
  localparam logic signed [2:0] ARITY_ZERO    = 3'sd0;
  localparam logic signed [2:0] ARITY_UNARY   = 3'sd1;
  localparam logic signed [2:0] ARITY_BINARY  = 3'sd2;
  localparam logic signed [2:0] ARITY_TERNARY = 3'sd3;
  localparam logic signed [4:0] PREC_WORD     = 5'sd0;
  localparam logic signed [4:0] PREC_UNARY    = 5'sd2;
  localparam logic signed [4:0] PREC_MUL      = 5'sd3;
  localparam logic signed [4:0] PREC_ADD      = 5'sd4;
  localparam logic signed [4:0] PREC_REL      = 5'sd6;
  localparam logic signed [4:0] PREC_EQEQ     = 5'sd7;
  localparam logic signed [4:0] PREC_COND     = 5'sd13;
  localparam logic signed [4:0] PREC_ASSIGN   = 5'sd14;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;

  // stimulus and expectations
  lex_in_t text_queue[$];
  token_t  token_queue[$];
  lex_in_t next_item;
  int      queued_items = 0;
  int      send_idle = 35;
  int      recv_idle = 78;
  logic    hold_armed = 1'b0;
  logic    hold_done = 1'b0;
  int      hold_left = 0;
  int      stall_cycles = 0;
  int      errors = 0;
  token_t  got_token;
  token_t  want_token;

  // lexer state mirror
  logic [15:0] pos;
  kind_t       prev_kind;
  logic        text_start;
  logic        in_word;
  logic [15:0] word_start;
  logic [16:0] word_len;
  kind_t       word_kind;
  logic        word_numeric;
  logic [1:0]  word_dots;
  logic        eq_held;
  logic [15:0] eq_pos;

  expression_lexer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // token prediction
  // --------------------------------------------------------------------------
  function automatic kind_t char_kind(input logic [7:0] b);
    case (b)
      CH_NUL:    return KIND_END;
      CH_BANG:   return KIND_BANG;
      CH_HASH:   return KIND_HASH;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_STAR:   return KIND_TIMES;
      CH_PLUS:   return KIND_PLUS;
      CH_MINUS:  return KIND_MINUS;
      CH_DOT:    return KIND_DOT;
      CH_SLASH:  return KIND_DIV;
      CH_COLON:  return KIND_COLON;
      CH_LT:     return KIND_LT;
      CH_EQUAL:  return KIND_EQ;
      CH_GT:     return KIND_GT;
      CH_QUEST:  return KIND_QUEST;
      CH_UNDERSCORE: return KIND_LETTER;
      default: begin
        if (b >= CH_ZERO && b < CH_COLON) return KIND_DIGIT;
        if (b >= CH_UPPER_A && b < CH_UPPER_END) return KIND_LETTER;
        if (b >= CH_LOWER_A && b < CH_LOWER_END) return KIND_LETTER;
        return KIND_OTHER;
      end
    endcase
  endfunction

  function automatic logic blank_char(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // a sign is unary at text start or right after an operator-like raw byte
  function automatic logic sign_is_unary();
    case (prev_kind)
      KIND_TIMES, KIND_DIV, KIND_PLUS, KIND_MINUS, KIND_LT, KIND_EQ, KIND_GT,
      KIND_LPAREN, KIND_QUEST, KIND_COLON: return 1'b1;
      default: return text_start;
    endcase
  endfunction

  task automatic restart_text();
    pos = 16'd0;
    prev_kind = KIND_END;
    text_start = 1'b1;
    in_word = 1'b0;
    word_start = 16'd0;
    word_len = 17'd0;
    word_kind = KIND_END;
    word_numeric = 1'b1;
    word_dots = 2'd0;
    eq_held = 1'b0;
    eq_pos = 16'd0;
  endtask

  task automatic emit(input kind_t k, input logic signed [3:0] code,
                      input logic signed [2:0] arity, input logic signed [4:0] prec,
                      input logic [15:0] start, input logic [16:0] len, input logic last);
    token_t t;
    t.kind = k;
    t.code = code;
    t.arity = arity;
    t.prec = prec;
    t.start = start;
    t.length = len;
    t.last = last;
    token_queue.insert(token_queue.size(), t);
  endtask

  task automatic close_word();
    logic numeric;
    numeric = word_numeric && word_dots != DOTS_SAT &&
              !(word_len == 17'd1 && word_kind == KIND_DOT);
    emit(word_kind, numeric ? OP_NUMERIC : OP_IDENT, ARITY_ZERO, PREC_WORD,
         word_start, word_len, 1'b0);
    in_word = 1'b0;
  endtask

  task automatic step_pos(input kind_t k, input logic blank);
    prev_kind = blank ? KIND_OTHER : k;   // whitespace still counts as a raw byte
    text_start = 1'b0;
    if (pos != POS_MAX) pos = pos + 16'd1;
  endtask

  task automatic lex_byte(input lex_in_t it);
    kind_t k;
    logic  blank;
    k = char_kind(it.text_byte);
    blank = blank_char(it.text_byte);

    // end of text or NUL: flush what is held, then the end token
    if (it.eot || k == KIND_END) begin
      if (in_word) close_word();
      if (eq_held) emit(KIND_EQ, OP_ASSIGN, ARITY_BINARY, PREC_ASSIGN, eq_pos, 17'd1, 1'b0);
      emit(KIND_END, OP_NONE, ARITY_NONE, PREC_NONE, pos, 17'd0, 1'b1);
      restart_text();
      return;
    end

    if (in_word) begin
      if (k == KIND_LETTER || k == KIND_DIGIT || k == KIND_DOT) begin
        if (word_len != LEN_MAX) word_len = word_len + 17'd1;
        if (k == KIND_LETTER) word_numeric = 1'b0;
        if (k == KIND_DOT && word_dots != DOTS_SAT) word_dots = word_dots + 2'd1;
        step_pos(k, blank);
        return;
      end
      close_word();
    end

    if (eq_held) begin
      eq_held = 1'b0;
      if (k == KIND_EQ) begin
        emit(KIND_EQ, OP_EQEQ, ARITY_BINARY, PREC_EQEQ, eq_pos, 17'd2, 1'b0);
        step_pos(k, blank);
        return;
      end
      emit(KIND_EQ, OP_ASSIGN, ARITY_BINARY, PREC_ASSIGN, eq_pos, 17'd1, 1'b0);
    end

    if (blank) begin
      step_pos(k, blank);
      return;
    end

    case (k)
      KIND_LETTER, KIND_DIGIT, KIND_DOT: begin
        in_word = 1'b1;
        word_start = pos;
        word_len = 17'd1;
        word_kind = k;
        word_numeric = (k != KIND_LETTER);
        word_dots = (k == KIND_DOT) ? 2'd1 : 2'd0;
      end
      KIND_EQ: begin
        eq_held = 1'b1;
        eq_pos = pos;
      end
      KIND_TIMES: emit(k, OP_TIMES, ARITY_BINARY, PREC_MUL, pos, 17'd1, 1'b0);
      KIND_DIV:   emit(k, OP_DIV, ARITY_BINARY, PREC_MUL, pos, 17'd1, 1'b0);
      KIND_PLUS: begin
        if (sign_is_unary()) emit(k, OP_UPLUS, ARITY_UNARY, PREC_UNARY, pos, 17'd1, 1'b0);
        else emit(k, OP_PLUS, ARITY_BINARY, PREC_ADD, pos, 17'd1, 1'b0);
      end
      KIND_MINUS: begin
        if (sign_is_unary()) emit(k, OP_UMINUS, ARITY_UNARY, PREC_UNARY, pos, 17'd1, 1'b0);
        else emit(k, OP_MINUS, ARITY_BINARY, PREC_ADD, pos, 17'd1, 1'b0);
      end
      KIND_LT:    emit(k, OP_LT, ARITY_BINARY, PREC_REL, pos, 17'd1, 1'b0);
      KIND_GT:    emit(k, OP_GT, ARITY_BINARY, PREC_REL, pos, 17'd1, 1'b0);
      KIND_QUEST: emit(k, OP_QUEST, ARITY_ZERO, PREC_COND, pos, 17'd1, 1'b0);
      KIND_COLON: emit(k, OP_COLON, ARITY_TERNARY, PREC_COND, pos, 17'd1, 1'b0);
      default:    emit(k, OP_NONE, ARITY_NONE, PREC_NONE, pos, 17'd1, 1'b0);
    endcase
    step_pos(k, blank);
  endtask

  // --------------------------------------------------------------------------
  // text generation
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [7:0] b, input logic eot);
    lex_in_t it;
    it.text_byte = b;
    it.eot = eot;
    text_queue.insert(text_queue.size(), it);
    queued_items++;
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return CH_UPPER_A + r[7:0];
    if (r < 52) return CH_LOWER_A + r[7:0] - 8'd26;
    return CH_UNDERSCORE;
  endfunction

  function automatic logic [7:0] pick_digit();
    int r;
    r = $urandom_range(9);
    return CH_ZERO + r[7:0];
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(9))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      3: return CH_SLASH;
      4: return CH_LT;
      5: return CH_GT;
      6: return CH_QUEST;
      7: return CH_COLON;
      8: return CH_LPAREN;
      default: return CH_RPAREN;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(5);
    if (r == 5) return CH_SPACE;
    return CH_TAB + r[7:0];
  endfunction

  // mostly expression-shaped text with some noise, closed by end of text or NUL
  task automatic add_random_text();
    int pieces;
    int r;
    int n;
    pieces = $urandom_range(14);
    for (int p = 0; p < pieces; p++) begin
      r = $urandom_range(99);
      if (r < 22) begin
        push_item(pick_letter(), 1'b0);
        n = $urandom_range(5);
        repeat (n) push_item($urandom_range(1) ? pick_letter() : pick_digit(), 1'b0);
      end else if (r < 38) begin
        // numbers, sometimes with a second dot or as a lone dot
        if ($urandom_range(9) == 0) begin
          push_item(CH_DOT, 1'b0);
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) push_item(pick_digit(), 1'b0);
          if ($urandom_range(2) == 0) push_item(CH_DOT, 1'b0);
          if ($urandom_range(1) == 0) push_item(pick_digit(), 1'b0);
          if ($urandom_range(9) == 0) push_item(CH_DOT, 1'b0);
        end
      end else if (r < 60) begin
        push_item(pick_operator(), 1'b0);
      end else if (r < 68) begin
        push_item(CH_EQUAL, 1'b0);
        if ($urandom_range(1)) push_item(CH_EQUAL, 1'b0);
      end else if (r < 82) begin
        push_item(pick_blank(), 1'b0);
      end else if (r < 90) begin
        push_item($urandom_range(1) ? CH_BANG : CH_HASH, 1'b0);
      end else begin
        push_item(8'($urandom_range(1, 255)), 1'b0);
      end
    end
    if ($urandom_range(3) != 0) push_item(8'($urandom_range(255)), 1'b1);
    else push_item(CH_NUL, 1'b0);
  endtask

  task automatic add_random_phase();
    int target;
    target = queued_items + PHASE_ITEMS;
    while (queued_items < target) add_random_text();
  endtask

  task automatic wait_drained();
    while (text_queue.size() != 0 || s_tvalid || token_queue.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // byte driver: predicts on every accepted request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) lex_byte({s_tlast, s_tdata});
      if (!s_tvalid || s_tready) begin
        if (text_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_item = text_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= next_item.text_byte;
          s_tlast <= next_item.eot;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // token monitor and back-pressure
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: token %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_token = {m_tlast, m_tdata[49:0]};
        if (token_queue.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected token, expected none, actual %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          want_token = token_queue.pop_front();
          check_field("kind", want_token.kind, got_token.kind);
          check_field("op_code", want_token.code, got_token.code);
          check_field("arity", want_token.arity, got_token.arity);
          check_field("precedence", want_token.prec, got_token.prec);
          check_field("start", want_token.start, got_token.start);
          check_field("length", want_token.length, got_token.length);
          check_field("last", want_token.last, got_token.last);
        end
      end
      // one long hold-off once the final phase begins, so the token queue fills
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
        m_tready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    restart_text();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // unary plus at start, '=' then unary minus, '==', lone dot, word at end
    push_string("+_9=-(3.5==.)x");
    push_item(8'hFF, 1'b1);
    // high byte, binary minus, double-dot word, all binary operators,
    // '=' pending at a NUL
    push_item(8'hFF, 1'b0);
    push_string("-1..x+<>?:*/=");
    push_item(CH_NUL, 1'b0);
    add_random_phase();
    wait_drained();

    send_idle = 78;
    recv_idle = 35;
    add_random_phase();
    wait_drained();

    // no idling; long hold-off at the start, then a few short texts
    send_idle = 0;
    recv_idle = 0;
    hold_armed = 1'b1;
    add_random_phase();
    push_item(CH_PLUS, 1'b0);
    push_item(CH_NUL, 1'b1);
    push_string("a=b");
    push_item(CH_NUL, 1'b1);
    wait_drained();

    repeat (8) @(negedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/elx_pkg.sv
rtl/elx_core.sv
rtl/elx_token_fifo.sv
rtl/expression_lexer.sv
test/expression_lexer_tb.sv
